/* hw/rtl/atsr_pkg.sv */
package atsr_pkg;

    localparam int MAX_PARAMS = 8;
    localparam int NUM_KEPT   = 5;
    localparam int PCNT_W     = $clog2(MAX_PARAMS + 1);
    localparam int ACC_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int QDEPTH     = 2;

    localparam logic [1:0] MODE_TEXT = 2'd0;
    localparam logic [1:0] MODE_ESC  = 2'd1;
    localparam logic [1:0] MODE_SEQ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE  = 2'd2;

    localparam logic [7:0] CHAR_ESC   = 8'h1b;
    localparam logic [7:0] CHAR_LBRKT = 8'h5b;
    localparam logic [7:0] CHAR_M     = 8'h6d;
    localparam logic [7:0] CHAR_SEMI  = 8'h3b;
    localparam logic [7:0] CHAR_0     = 8'h30;
    localparam logic [7:0] CHAR_9     = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_HIGH  = 8'h80;

    localparam logic [ACC_W-1:0] SGR_FG  = 32'd38;
    localparam logic [ACC_W-1:0] SGR_RGB = 32'd2;
    localparam logic [ACC_W-1:0] SGR_RST = 32'd0;
    localparam logic [3:0]       DEC_BASE = 4'd10;

    localparam logic [7:0] RESET_RED   = 8'd131;
    localparam logic [7:0] RESET_GREEN = 8'd148;
    localparam logic [7:0] RESET_BLUE  = 8'd150;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } color_t;

    typedef struct packed {
        logic       has_text;
        logic [7:0] text_byte;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       run_start;
        logic       line_done;
        logic       last_of_item;
    } result_t;

    function automatic result_t text_result(input logic [7:0] ch, input color_t col,
                                            input logic rs);
        result_t res;
        res.has_text     = 1'b1;
        res.text_byte    = ch;
        res.red          = col.r;
        res.green        = col.g;
        res.blue         = col.b;
        res.run_start    = rs;
        res.line_done    = 1'b0;
        res.last_of_item = 1'b0;
        return res;
    endfunction

    function automatic result_t marker_result();
        result_t res;
        res              = '0;
        res.line_done    = 1'b1;
        res.last_of_item = 1'b1;
        return res;
    endfunction

endpackage

/* hw/rtl/atsr_in_if.sv */
interface atsr_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] in_byte;

    modport source (output valid, output opcode, output in_byte, input ready);
    modport sink   (input valid, input opcode, input in_byte, output ready);
endinterface

/* hw/rtl/atsr_out_if.sv */
interface atsr_out_if;
    logic       valid;
    logic       ready;
    logic       has_text;
    logic [7:0] text_byte;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       run_start;
    logic       line_done;
    logic       last_of_item;

    modport source (output valid, output has_text, output text_byte, output red,
                    output green, output blue, output run_start, output line_done,
                    output last_of_item, input ready);
    modport sink   (input valid, input has_text, input text_byte, input red,
                    input green, input blue, input run_start, input line_done,
                    input last_of_item, output ready);
endinterface

/* hw/rtl/ansi_truecolor_sgr_run_splitter.sv */
// Strips ESC-[ ... m sequences from a byte stream and tags each visible byte with its
// 38;2;r;g;b color and a run-start flag; an end-of-line beat yields a line_done result.
// An accepted beat lands in an input register, is decoded into a two-entry result
// queue register, and the head of that queue drives the result port.
// The block takes one input beat per cycle while results drain; a beat that yields two
// results (a held ESC followed by a byte other than '[' or ESC, or a held ESC at end
// of line) needs two result beats, so the sustained rate is one result beat per cycle
// at the result port while result.ready is held high.
// Default color registers are written through cfg_wr_en / cfg_index / cfg_data and
// take effect at the next line start or on a reset (0) parameter.
module ansi_truecolor_sgr_run_splitter
    import atsr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    atsr_in_if.sink              item,
    atsr_out_if.source           result
);

    logic              in_vld_reg;
    logic              in_op_reg;
    logic [7:0]        in_byte_reg;

    color_t            dflt_reg;
    color_t            cur_reg, cur_next;
    logic [1:0]        mode_reg, mode_next;
    logic [ACC_W-1:0]  pv_reg [NUM_KEPT];
    logic [ACC_W-1:0]  pv_next [NUM_KEPT];
    logic [ACC_W-1:0]  pv_f [NUM_KEPT];
    logic [PCNT_W-1:0] pcnt_reg, pcnt_next, pcnt_f;
    logic [ACC_W-1:0]  acc_reg, acc_next, acc_mul;
    logic              rp_reg, rp_next;

    result_t           q_reg [QDEPTH];
    result_t           q_next [QDEPTH];
    logic [1:0]        qcnt_reg, qcnt_next, qcnt_ap;

    result_t           r0, r1;
    logic [1:0]        n_res;
    logic [1:0]        mode_eff;
    color_t            fin_color;
    logic              pop, fits, proc, is_ctrl, is_digit;

    // output side
    assign pop                 = result.valid && result.ready;
    assign result.valid        = (qcnt_reg != 2'd0);
    assign result.has_text     = q_reg[0].has_text;
    assign result.text_byte    = q_reg[0].text_byte;
    assign result.red          = q_reg[0].red;
    assign result.green        = q_reg[0].green;
    assign result.blue         = q_reg[0].blue;
    assign result.run_start    = q_reg[0].run_start;
    assign result.line_done    = q_reg[0].line_done;
    assign result.last_of_item = q_reg[0].last_of_item;

    assign qcnt_ap    = qcnt_reg - {1'b0, pop};
    assign fits       = ({1'b0, qcnt_ap} + {1'b0, n_res}) <= 3'(QDEPTH);
    assign proc       = in_vld_reg && fits;
    assign item.ready = !in_vld_reg || proc;

    assign mode_eff = (mode_reg == MODE_SEQ || mode_reg == MODE_ESC) ? mode_reg : MODE_TEXT;
    assign is_ctrl  = (in_byte_reg < CHAR_SPACE) || (in_byte_reg >= CHAR_HIGH);
    assign is_digit = (in_byte_reg >= CHAR_0) && (in_byte_reg <= CHAR_9);
    assign acc_mul  = acc_reg * ACC_W'(DEC_BASE) + ACC_W'(in_byte_reg - CHAR_0);

    // parameter push and sequence close
    always_comb
    begin
        for (int i = 0; i < NUM_KEPT; i++)
        begin
            pv_f[i] = (pcnt_reg < PCNT_W'(MAX_PARAMS) && pcnt_reg == PCNT_W'(i))
                      ? acc_reg : pv_reg[i];
        end
        pcnt_f = (pcnt_reg < PCNT_W'(MAX_PARAMS)) ? pcnt_reg + PCNT_W'(1) : pcnt_reg;
        if (pcnt_f >= PCNT_W'(NUM_KEPT) && pv_f[0] == SGR_FG && pv_f[1] == SGR_RGB)
        begin
            fin_color = '{r: pv_f[2][7:0], g: pv_f[3][7:0], b: pv_f[4][7:0]};
        end
        else if (pv_f[0] == SGR_RST)
        begin
            fin_color = dflt_reg;
        end
        else
        begin
            fin_color = cur_reg;
        end
    end

    // decode
    always_comb
    begin
        mode_next = mode_reg;
        cur_next  = cur_reg;
        pcnt_next = pcnt_reg;
        acc_next  = acc_reg;
        rp_next   = rp_reg;
        n_res     = 2'd0;
        r0        = '0;
        r1        = '0;
        for (int i = 0; i < NUM_KEPT; i++)
        begin
            pv_next[i] = pv_reg[i];
        end

        if (in_op_reg)
        begin
            if (mode_eff == MODE_ESC)
            begin
                r0    = text_result(CHAR_ESC, cur_reg, rp_reg);
                r1    = marker_result();
                n_res = 2'd2;
            end
            else
            begin
                r0    = marker_result();
                n_res = 2'd1;
            end
            mode_next = MODE_TEXT;
            cur_next  = dflt_reg;
            pcnt_next = '0;
            acc_next  = '0;
            rp_next   = 1'b1;
        end
        else
        begin
            case (mode_eff)
                MODE_ESC:
                begin
                    if (in_byte_reg == CHAR_LBRKT)
                    begin
                        mode_next = MODE_SEQ;
                        pcnt_next = '0;
                        acc_next  = '0;
                        rp_next   = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_TEXT;
                        r0        = text_result(CHAR_ESC, cur_reg, rp_reg);
                        rp_next   = 1'b0;
                        if (in_byte_reg == CHAR_ESC)
                        begin
                            mode_next = MODE_ESC;
                            n_res     = 2'd1;
                        end
                        else
                        begin
                            r1    = text_result(in_byte_reg, cur_reg, 1'b0);
                            n_res = 2'd2;
                        end
                    end
                end
                MODE_SEQ:
                begin
                    if (in_byte_reg == CHAR_M || is_ctrl)
                    begin
                        pv_next   = pv_f;
                        pcnt_next = pcnt_f;
                        acc_next  = '0;
                        cur_next  = fin_color;
                        mode_next = MODE_TEXT;
                        if (is_ctrl)
                        begin
                            if (in_byte_reg == CHAR_ESC)
                            begin
                                mode_next = MODE_ESC;
                            end
                            else
                            begin
                                r0      = text_result(in_byte_reg, fin_color, rp_reg);
                                n_res   = 2'd1;
                                rp_next = 1'b0;
                            end
                        end
                    end
                    else if (is_digit)
                    begin
                        acc_next = acc_mul;
                    end
                    else if (in_byte_reg == CHAR_SEMI)
                    begin
                        pv_next   = pv_f;
                        pcnt_next = pcnt_f;
                        acc_next  = '0;
                    end
                end
                default:
                begin
                    if (in_byte_reg == CHAR_ESC)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else
                    begin
                        r0      = text_result(in_byte_reg, cur_reg, rp_reg);
                        n_res   = 2'd1;
                        rp_next = 1'b0;
                    end
                end
            endcase
        end

        if (n_res == 2'd1)
        begin
            r0.last_of_item = 1'b1;
        end
        if (n_res == 2'd2)
        begin
            r1.last_of_item = 1'b1;
        end
    end

    // result queue
    always_comb
    begin
        q_next[0] = pop ? q_reg[1] : q_reg[0];
        q_next[1] = q_reg[1];
        if (proc)
        begin
            if (qcnt_ap == 2'd0 && n_res != 2'd0)
            begin
                q_next[0] = r0;
            end
            if (qcnt_ap == 2'd1 && n_res != 2'd0)
            begin
                q_next[1] = r0;
            end
            if (qcnt_ap == 2'd0 && n_res == 2'd2)
            begin
                q_next[1] = r1;
            end
        end
        qcnt_next = qcnt_ap + (proc ? n_res : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            qcnt_reg   <= '0;
            mode_reg   <= MODE_TEXT;
            cur_reg    <= '{r: RESET_RED, g: RESET_GREEN, b: RESET_BLUE};
            dflt_reg   <= '{r: RESET_RED, g: RESET_GREEN, b: RESET_BLUE};
            pcnt_reg   <= '0;
            acc_reg    <= '0;
            rp_reg     <= 1'b1;
        end
        else
        begin
            if (item.ready)
            begin
                in_vld_reg <= item.valid;
            end
            qcnt_reg <= qcnt_next;
            if (proc)
            begin
                mode_reg <= mode_next;
                cur_reg  <= cur_next;
                pcnt_reg <= pcnt_next;
                acc_reg  <= acc_next;
                rp_reg   <= rp_next;
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_RED:   dflt_reg.r <= cfg_data;
                    CFG_GREEN: dflt_reg.g <= cfg_data;
                    CFG_BLUE:  dflt_reg.b <= cfg_data;
                    default:   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_op_reg   <= item.opcode;
            in_byte_reg <= item.in_byte;
        end
        if (proc)
        begin
            pv_reg <= pv_next;
        end
        q_reg <= q_next;
    end

    a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= 2'(QDEPTH))
        else $error("result queue overfilled");

    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        proc && in_op_reg |=> mode_reg == MODE_TEXT && rp_reg && pcnt_reg == '0)
        else $error("end of line did not clear parser state");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !proc |=> in_vld_reg && $stable(in_byte_reg) && $stable(in_op_reg))
        else $error("held input beat lost");

    a_seq_silent: assert property (@(posedge clk) disable iff (!rst_n)
        proc && !in_op_reg && mode_eff == MODE_SEQ && !is_ctrl |-> n_res == 2'd0)
        else $error("sequence byte produced output");

endmodule
